FILE: sv/cct_pkg.sv
`default_nettype none

package cct_pkg;

    localparam int CHAR_W = 16;
    localparam int OUT_OFF_W = 16;
    localparam int QUEUE_DEPTH = 4;

    // input actions
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_CHAR = 2'd1;
    localparam logic [1:0] ACT_END  = 2'd2;

    // character classes
    typedef logic [1:0] t_class;
    localparam t_class CLS_ALLOW = 2'd0;
    localparam t_class CLS_DELIM = 2'd1;
    localparam t_class CLS_SPACE = 2'd2;
    localparam t_class CLS_UNITE = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_PRIMARY = 2'd0;
    localparam logic [1:0] KIND_DELIM   = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    // modes
    localparam logic [1:0] MODE_PRIMARY_ONLY = 2'd1;

    typedef enum logic [1:0] {
        RUN_IDLE  = 2'd0,
        RUN_TERM  = 2'd1,
        RUN_DELIM = 2'd2
    } t_run;

    // classified word handed from front to back
    typedef struct packed {
        logic              is_end;
        logic [CHAR_W-1:0] ch;
        t_class            cls;
    } t_tok;

    typedef struct packed {
        logic [1:0]           kind;
        logic [CHAR_W-1:0]    out_char;
        logic [OUT_OFF_W-1:0] word_offset;
        logic                 term_last;
        logic                 empty_string;
    } t_res;

endpackage

`default_nettype wire

FILE: sv/cct_if.sv
`default_nettype none

interface cct_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] char_code;
    logic [1:0]  class_value;

    modport source (output valid, action, char_code, class_value, input ready);
    modport sink (input valid, action, char_code, class_value, output ready);
endinterface

interface cct_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] out_char;
    logic [15:0] word_offset;
    logic        term_last;
    logic        empty_string;

    modport source (output valid, kind, out_char, word_offset, term_last, empty_string,
                    input ready);
    modport sink (input valid, kind, out_char, word_offset, term_last, empty_string,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/cct_ram.sv
`default_nettype none

module cct_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/cct_front.sv
`default_nettype none

module cct_front import cct_pkg::*; #(
    parameter int TABLE_DEPTH = 65536
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cct_in_if.sink    i_in,
    output t_tok      o_tok,
    output logic      o_tok_valid,
    input  wire logic i_tok_full
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic              r_s1_valid;
    logic [1:0]        r_s1_action;
    logic [CHAR_W-1:0] r_s1_char;
    logic              r_s1_inrange;

    logic          accept;
    logic          advance;
    logic          in_range;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_class        ram_wdata;
    t_class        ram_rdata;

    assign in_range = 32'(i_in.char_code) < 32'(TABLE_DEPTH);
    assign i_in.ready = !r_clr_busy && (!r_s1_valid || !i_tok_full);
    assign accept = i_in.valid && i_in.ready;
    assign advance = r_s1_valid && !i_tok_full;

    // clearing sweep owns the write port until it finishes
    assign ram_we = r_clr_busy || (accept && i_in.action == ACT_LOAD && in_range);
    assign ram_waddr = r_clr_busy ? r_clr_addr : i_in.char_code[AW-1:0];
    assign ram_wdata = r_clr_busy ? CLS_ALLOW : i_in.class_value;

    cct_ram #(
        .WIDTH ($bits(t_class)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (i_in.char_code[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_busy <= (r_clr_addr != LAST_ADDR);
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_action  <= i_in.action;
            r_s1_char    <= i_in.char_code;
            r_s1_inrange <= in_range;
        end
    end

    // loads and unknown actions end here
    assign o_tok_valid = advance && (r_s1_action == ACT_CHAR || r_s1_action == ACT_END);
    assign o_tok.is_end = (r_s1_action == ACT_END);
    assign o_tok.ch = r_s1_char;
    assign o_tok.cls = r_s1_inrange ? ram_rdata : CLS_ALLOW;

endmodule

`default_nettype wire

FILE: sv/cct_fifo.sv
`default_nettype none

module cct_fifo import cct_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_tok i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_tok      o_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_tok          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full = (r_count == (PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: sv/cct_back.sv
`default_nettype none

module cct_back import cct_pkg::*; #(
    parameter int OFFSET_BITS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [1:0] i_mode,
    input  wire logic       i_tok_valid,
    input  wire t_tok       i_tok,
    output logic            o_pop,
    cct_out_if.source       o_out
);

    t_run                   r_run;
    logic                   r_held_valid;
    logic [CHAR_W-1:0]      r_held_char;
    logic                   r_held_kind;
    logic [OFFSET_BITS-1:0] r_held_offset;
    logic [OFFSET_BITS-1:0] r_wc;
    logic                   r_prev_delim;
    logic                   r_any_seen;

    logic r_out_valid;
    t_res r_out;
    logic r_pend_valid;
    t_res r_pend;

    t_run                   n_run;
    logic                   n_held_valid;
    logic [CHAR_W-1:0]      n_held_char;
    logic                   n_held_kind;
    logic [OFFSET_BITS-1:0] n_held_offset;
    logic [OFFSET_BITS-1:0] n_wc;
    logic                   n_prev_delim;
    logic                   n_any_seen;

    logic                   out_free;
    logic                   drop;
    logic                   term_cls;
    logic                   close_run;
    logic                   cont_run;
    logic                   load_new;
    logic [OFFSET_BITS-1:0] wc1;
    logic [31:0]            off_ext;
    logic [1:0]             nres;
    t_res                   res0;
    t_res                   res1;
    t_res                   held_res;
    t_res                   end_res;

    function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
        sat_inc = (v == '1) ? v : v + OFFSET_BITS'(1);
    endfunction

    assign out_free = !r_out_valid || o_out.ready;
    assign o_pop = i_tok_valid && out_free && !r_pend_valid;

    // next run state
    always_comb begin
        n_run = r_run;
        if (i_tok.is_end) begin
            n_run = RUN_IDLE;
        end else begin
            unique case (i_tok.cls)
                CLS_ALLOW, CLS_UNITE: n_run = RUN_TERM;
                CLS_SPACE:            n_run = RUN_IDLE;
                default:              n_run = drop ? RUN_IDLE : RUN_DELIM;
            endcase
        end
    end

    // results and stream datapath
    always_comb begin
        drop = (i_mode == MODE_PRIMARY_ONLY);
        term_cls = (i_tok.cls == CLS_ALLOW) || (i_tok.cls == CLS_UNITE);
        wc1 = (drop && r_prev_delim && i_tok.cls != CLS_DELIM) ? sat_inc(r_wc) : r_wc;
        close_run = (term_cls && r_run != RUN_TERM) || (i_tok.cls == CLS_SPACE)
                  || (i_tok.cls == CLS_DELIM && (drop || r_run != RUN_DELIM));
        cont_run = (i_tok.cls == CLS_ALLOW && r_run == RUN_TERM)
                 || (i_tok.cls == CLS_DELIM && !drop && r_run == RUN_DELIM);
        load_new = (i_tok.cls == CLS_ALLOW) || (i_tok.cls == CLS_DELIM && !drop);

        off_ext = 32'(r_held_offset);
        held_res.kind = r_held_kind ? KIND_DELIM : KIND_PRIMARY;
        held_res.out_char = r_held_char;
        held_res.word_offset = off_ext[OUT_OFF_W-1:0];
        held_res.term_last = 1'b1;
        held_res.empty_string = 1'b0;

        end_res.kind = KIND_END;
        end_res.out_char = '0;
        end_res.word_offset = '0;
        end_res.term_last = 1'b0;
        end_res.empty_string = !r_any_seen;

        res0 = held_res;
        res1 = end_res;
        nres = 2'd0;
        n_held_valid = r_held_valid;
        n_held_char = r_held_char;
        n_held_kind = r_held_kind;
        n_held_offset = r_held_offset;
        n_wc = r_wc;
        n_prev_delim = r_prev_delim;
        n_any_seen = r_any_seen;

        if (i_tok.is_end) begin
            // flush the held character, then mark the end; clear the stream
            nres = r_held_valid ? 2'd2 : 2'd1;
            res0 = r_held_valid ? held_res : end_res;
            n_held_valid = 1'b0;
            n_held_char = '0;
            n_held_kind = 1'b0;
            n_held_offset = '0;
            n_wc = '0;
            n_prev_delim = 1'b0;
            n_any_seen = 1'b0;
        end else begin
            nres = (r_held_valid && (close_run || cont_run)) ? 2'd1 : 2'd0;
            res0.term_last = close_run;
            n_wc = (close_run && r_held_valid) ? sat_inc(wc1) : wc1;
            if (load_new) begin
                n_held_valid = 1'b1;
                n_held_char = i_tok.ch;
                n_held_kind = (i_tok.cls == CLS_DELIM);
                n_held_offset = n_wc;
            end else if (close_run) begin
                n_held_valid = 1'b0;
            end
            n_prev_delim = (i_tok.cls == CLS_DELIM);
            n_any_seen = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run        <= RUN_IDLE;
            r_held_valid <= 1'b0;
            r_wc         <= '0;
            r_prev_delim <= 1'b0;
            r_any_seen   <= 1'b0;
        end else if (o_pop) begin
            r_run        <= n_run;
            r_held_valid <= n_held_valid;
            r_wc         <= n_wc;
            r_prev_delim <= n_prev_delim;
            r_any_seen   <= n_any_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_held_char   <= n_held_char;
            r_held_kind   <= n_held_kind;
            r_held_offset <= n_held_offset;
        end
    end

    // output slot plus one pending slot for the second result of an end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (out_free) begin
            if (r_pend_valid) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (o_pop && nres != 2'd0) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= (nres == 2'd2);
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend_valid) begin
                r_out <= r_pend;
            end else if (o_pop) begin
                r_out  <= res0;
                r_pend <= res1;
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.kind = r_out.kind;
    assign o_out.out_char = r_out.out_char;
    assign o_out.word_offset = r_out.word_offset;
    assign o_out.term_last = r_out.term_last;
    assign o_out.empty_string = r_out.empty_string;

endmodule

`default_nettype wire

FILE: sv/char_class_tokenizer_core.sv
// Channel   Dir  Handshake      Word fields
// i_in      in   valid/ready    action, char_code, class_value
// o_out     out  valid/ready    kind, out_char, word_offset, term_last, empty_string
// config    in   i_cfg_we       i_cfg_wdata (mode)
//
// One input word per cycle while the queue has room; the words a character causes
// reach o_out through the table read, the queue and then the output register.
// An end of string that flushes a held character gives two output words and holds
// the back end until the second word has moved into the output register.
// After reset the class table is swept to allow, one entry a cycle, so i_in.ready
// stays low until every entry is written. Front and back stall separately across a
// four-word queue; the queue keeps taking words while a result waits at the output.
`default_nettype none

module char_class_tokenizer_core import cct_pkg::*; #(
    parameter int TABLE_DEPTH = 65536,
    parameter int OFFSET_BITS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_wdata,
    cct_in_if.sink          i_in,
    cct_out_if.source       o_out
);

    // mode register: the user must write it only while the block is idle; not enforced here
    logic [1:0] r_mode;

    // front to queue
    t_tok front_tok;
    logic front_tok_valid;
    logic queue_full;

    // queue to back
    t_tok queue_tok;
    logic queue_valid;
    logic back_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // front: accept, look up the class, drop loads and unknown actions
    cct_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_tok       (front_tok),
        .o_tok_valid (front_tok_valid),
        .i_tok_full  (queue_full)
    );

    // decouple classification from term building
    cct_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_tok_valid),
        .i_data  (front_tok),
        .o_full  (queue_full),
        .i_pop   (back_pop),
        .o_valid (queue_valid),
        .o_data  (queue_tok)
    );

    // back: run tracking, hold one character behind, word offsets
    cct_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_mode),
        .i_tok_valid (queue_valid),
        .i_tok       (queue_tok),
        .o_pop       (back_pop),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import cct_pkg::*;

    // Test-side names for the codes the package leaves out
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [1:0] MODE_MIXED = 2'd0;
    localparam logic [1:0] MODE_RAW   = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Characters used by the directed tests
    localparam logic [15:0] CH_SPACE  = 16'h0020;
    localparam logic [15:0] CH_COMMA  = 16'h002C;
    localparam logic [15:0] CH_HYPHEN = 16'h002D;
    localparam logic [15:0] CH_A      = 16'h0061;
    localparam logic [15:0] CH_B      = 16'h0062;
    localparam logic [15:0] CH_C      = 16'h0063;

    localparam int SETTLE_CYCLES = 10;   // pipeline depth plus the flush of an end
    localparam int HOLD_CYCLES   = 200;  // long receiver hold-off

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_wdata;

    cct_in_if  word_in ();
    cct_out_if word_out ();

    char_class_tokenizer_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (word_in),
        .o_out       (word_out)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Tokenizer predictor: own copy of the class table, mode and the
    // streaming state; every accepted input word appends the output
    // words it causes to due_words.
    // ------------------------------------------------------------------
    t_class      class_of [0:65535];
    logic [1:0]  cur_mode;
    t_run        run_st;
    bit          held_ok;
    logic [15:0] held_ch;
    logic [1:0]  held_kd;
    logic [15:0] held_off;
    logic [15:0] word_count;
    bit          last_was_delim;
    bit          saw_char;
    t_res        due_words [$];

    int          error_count = 0;
    int          sender_gap_pct = 0;
    int          receiver_stall_pct = 0;
    logic        receiver_hold = 1'b0;
    event        hold_go;
    logic [15:0] char_pool [32];

    function automatic void push_word(logic [1:0] kind, logic [15:0] ch, logic [15:0] off,
                                      logic last, logic empty);
        t_res w;
        w.kind         = kind;
        w.out_char     = ch;
        w.word_offset  = off;
        w.term_last    = last;
        w.empty_string = empty;
        due_words.push_back(w);
    endfunction

    // Saturate rather than wrap
    function automatic void bump_offset();
        if (word_count != 16'hFFFF)
            word_count++;
    endfunction

    function automatic void release_held(logic last);
        if (held_ok) begin
            push_word(held_kd, held_ch, held_off, last, 1'b0);
            held_ok = 0;
        end
    endfunction

    // A run that emitted anything takes a word offset; a unite-only run does not
    function automatic void close_term();
        if (held_ok) begin
            release_held(1'b1);
            bump_offset();
        end
        run_st = RUN_IDLE;
    endfunction

    function automatic void hold_char(logic [15:0] ch, logic [1:0] kind);
        held_ok  = 1;
        held_ch  = ch;
        held_kd  = kind;
        held_off = word_count;
    endfunction

    function automatic void clear_stream();
        run_st         = RUN_IDLE;
        held_ok        = 0;
        held_ch        = '0;
        held_kd        = KIND_PRIMARY;
        held_off       = '0;
        word_count     = '0;
        last_was_delim = 0;
        saw_char       = 0;
    endfunction

    function automatic void predict_word(logic [1:0] act, logic [15:0] code, t_class load_cls);
        t_class cls;
        bit     drop_delims;
        drop_delims = (cur_mode == MODE_PRIMARY_ONLY);
        case (act)
            ACT_LOAD: begin
                class_of[code] = load_cls;
            end
            ACT_END: begin
                close_term();
                push_word(KIND_END, '0, '0, 1'b0, !saw_char);
                clear_stream();
            end
            ACT_CHAR: begin
                cls = class_of[code];
                saw_char = 1;
                // Primary-only mode: leaving a delimiter stretch steps the offset
                if (drop_delims && last_was_delim && cls != CLS_DELIM)
                    bump_offset();
                if (cls == CLS_ALLOW || cls == CLS_UNITE) begin
                    if (run_st != RUN_TERM)
                        close_term();
                    run_st = RUN_TERM;
                    if (cls == CLS_ALLOW) begin
                        release_held(1'b0);
                        hold_char(code, KIND_PRIMARY);
                    end
                end else if (cls == CLS_SPACE || drop_delims) begin
                    close_term();
                end else begin
                    if (run_st != RUN_DELIM)
                        close_term();
                    else
                        release_held(1'b0);
                    run_st = RUN_DELIM;
                    hold_char(code, KIND_DELIM);
                end
                last_was_delim = (cls == CLS_DELIM);
            end
            default: ;
        endcase
    endfunction

    function automatic string fmt_word(t_res w);
        return $sformatf("kind=%0d char=%h offset=%0d last=%b empty=%b",
                         w.kind, w.out_char, w.word_offset, w.term_last, w.empty_string);
    endfunction

    // ------------------------------------------------------------------
    // Receiver: drive ready at the falling edge, check at the rising edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (receiver_hold)
            word_out.ready <= 1'b0;
        else if (receiver_stall_pct != 0 && $urandom_range(99) < receiver_stall_pct)
            word_out.ready <= 1'b0;
        else
            word_out.ready <= 1'b1;
    end

    // Long hold-off, counted here so the sender keeps pushing meanwhile
    always begin
        @(hold_go);
        receiver_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        receiver_hold <= 1'b0;
    end

    t_res seen_word;
    t_res want_word;

    always @(posedge i_clk) begin
        if (i_rst_n && word_out.valid && word_out.ready) begin
            seen_word.kind         = word_out.kind;
            seen_word.out_char     = word_out.out_char;
            seen_word.word_offset  = word_out.word_offset;
            seen_word.term_last    = word_out.term_last;
            seen_word.empty_string = word_out.empty_string;
            if (due_words.size() == 0) begin
                error_count++;
                $display("%0t: unexpected word: expected none, got %s",
                         $time, fmt_word(seen_word));
            end else begin
                want_word = due_words.pop_front();
                if (seen_word !== want_word) begin
                    error_count++;
                    $display("%0t: mismatch: expected %s, got %s",
                             $time, fmt_word(want_word), fmt_word(seen_word));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender; entered and left just after a falling edge. Valid stays
    // high on exit, so whatever follows either sends or lowers it.
    // ------------------------------------------------------------------
    task automatic send_word(input logic [1:0] act, input logic [15:0] code,
                             input logic [1:0] cls);
        while (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct) begin
            word_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        word_in.valid       <= 1'b1;
        word_in.action      <= act;
        word_in.char_code   <= code;
        word_in.class_value <= cls;
        @(posedge i_clk);
        while (!word_in.ready)
            @(posedge i_clk);
        predict_word(act, code, cls);
        @(negedge i_clk);
    endtask

    // Drop valid, let every expected word arrive, then let loads settle
    task automatic wait_idle();
        word_in.valid <= 1'b0;
        while (due_words.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_mode(input logic [1:0] m);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_mode = m;
    endtask

    task automatic set_idling(input int gap_pct, input int stall_pct);
        sender_gap_pct     = gap_pct;
        receiver_stall_pct = stall_pct;
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Cleared table: extreme codes are allow; a second end reports an empty string
    task automatic test_defaults();
        set_mode(MODE_MIXED);
        send_word(ACT_CHAR, 16'h0000, CLS_ALLOW);
        send_word(ACT_CHAR, 16'hFFFF, CLS_ALLOW);
        send_word(ACT_END, 16'h0000, CLS_ALLOW);
        send_word(ACT_END, 16'hFFFF, CLS_UNITE);
        wait_idle();
    endtask

    // Every class in mixed mode: unite inside a term, a delimiter run,
    // a unite-only run that must vanish, flush on end
    task automatic test_classes();
        send_word(ACT_LOAD, CH_COMMA, CLS_DELIM);
        send_word(ACT_LOAD, CH_SPACE, CLS_SPACE);
        send_word(ACT_LOAD, CH_HYPHEN, CLS_UNITE);
        send_word(ACT_LOAD, 16'hFFFF, CLS_DELIM);
        send_word(ACT_CHAR, CH_A, CLS_ALLOW);
        send_word(ACT_CHAR, CH_HYPHEN, CLS_ALLOW);
        send_word(ACT_CHAR, CH_B, CLS_ALLOW);
        send_word(ACT_CHAR, CH_COMMA, CLS_ALLOW);
        send_word(ACT_CHAR, 16'hFFFF, CLS_ALLOW);
        send_word(ACT_CHAR, CH_SPACE, CLS_ALLOW);
        send_word(ACT_CHAR, CH_HYPHEN, CLS_ALLOW);
        send_word(ACT_CHAR, CH_HYPHEN, CLS_ALLOW);
        send_word(ACT_CHAR, CH_SPACE, CLS_ALLOW);
        send_word(ACT_CHAR, CH_C, CLS_ALLOW);
        send_word(ACT_END, '0, CLS_ALLOW);
        wait_idle();
    endtask

    // Primary-only mode: delimiters vanish but step the offset; unknown action ignored
    task automatic test_primary_only();
        set_mode(MODE_PRIMARY_ONLY);
        send_word(ACT_CHAR, CH_A, CLS_ALLOW);
        send_word(ACT_CHAR, CH_COMMA, CLS_ALLOW);
        send_word(ACT_UNUSED, CH_B, CLS_SPACE);
        send_word(ACT_CHAR, CH_COMMA, CLS_ALLOW);
        send_word(ACT_CHAR, CH_B, CLS_ALLOW);
        send_word(ACT_CHAR, CH_HYPHEN, CLS_ALLOW);
        send_word(ACT_CHAR, CH_SPACE, CLS_ALLOW);
        send_word(ACT_CHAR, CH_C, CLS_ALLOW);
        send_word(ACT_END, '0, CLS_ALLOW);
        wait_idle();
    endtask

    // Each allow/delimiter pair steps the offset twice; a long string climbs it
    task automatic test_offset_climb();
        set_mode(MODE_PRIMARY_ONLY);
        set_idling(0, 0);
        send_word(ACT_LOAD, CH_A, CLS_ALLOW);
        send_word(ACT_LOAD, CH_COMMA, CLS_DELIM);
        repeat (150) begin
            send_word(ACT_CHAR, CH_A, CLS_ALLOW);
            send_word(ACT_CHAR, CH_COMMA, CLS_ALLOW);
        end
        send_word(ACT_END, '0, CLS_ALLOW);
        wait_idle();
    endtask

    // Hold the receiver off long enough that the queue fills and input stalls
    task automatic test_backpressure();
        logic [15:0] mix [3];
        mix = '{CH_A, CH_COMMA, CH_SPACE};
        set_mode(MODE_MIXED);
        set_idling(0, 0);
        -> hold_go;
        repeat (40)
            send_word(ACT_CHAR, mix[$urandom_range(2)], CLS_ALLOW);
        send_word(ACT_END, '0, CLS_ALLOW);
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Random strings over a small loaded alphabet, with noise
    // ------------------------------------------------------------------
    function automatic logic [15:0] pick_char();
        if ($urandom_range(3) != 0)
            return char_pool[$urandom_range(31)];
        return 16'($urandom);
    endfunction

    task automatic send_random_load();
        logic [15:0] addr;
        addr = ($urandom_range(1) != 0) ? char_pool[$urandom_range(31)] : 16'($urandom);
        send_word(ACT_LOAD, addr, 2'($urandom_range(3)));
    endtask

    // Mostly well-formed strings; some skip the end so the next one runs on
    task automatic send_random_string(inout int sent);
        int len;
        int r;
        len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(99);
            if (r < 4) begin
                send_random_load();
                sent++;
            end else if (r < 6) begin
                send_word(ACT_UNUSED, 16'($urandom), 2'($urandom));
            end else begin
                send_word(ACT_CHAR, pick_char(), 2'($urandom));
                sent++;
            end
        end
        if ($urandom_range(9) != 0) begin
            send_word(ACT_END, 16'($urandom), 2'($urandom));
            sent++;
        end
    endtask

    task automatic test_random();
        logic [1:0] modes [8];
        int         gaps [4];
        int         stalls [4];
        int         sent;
        modes  = '{MODE_RAW, MODE_PRIMARY_ONLY, MODE_SPARE, MODE_MIXED,
                   MODE_PRIMARY_ONLY, MODE_RAW, MODE_MIXED, MODE_SPARE};
        gaps   = '{0, 50, 0, 18};
        stalls = '{0, 0, 50, 18};
        // Seed the alphabet so every class shows up from the start
        for (int i = 0; i < 32; i++) begin
            char_pool[i] = 16'($urandom);
            send_word(ACT_LOAD, char_pool[i], 2'(i % 4));
        end
        for (int p = 0; p < 8; p++) begin
            // Mode changes may land mid-string; they apply from the next character
            set_mode(modes[p]);
            set_idling(gaps[p % 4], stalls[p % 4]);
            sent = 0;
            while (sent < 200)
                send_random_string(sent);
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = MODE_MIXED;
        word_in.valid       = 1'b0;
        word_in.action      = ACT_LOAD;
        word_in.char_code   = '0;
        word_in.class_value = CLS_ALLOW;
        word_out.ready      = 1'b0;
        foreach (class_of[i])
            class_of[i] = CLS_ALLOW;
        cur_mode = MODE_MIXED;
        clear_stream();

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The table sweep after reset keeps input ready low; the sender just waits
        test_defaults();
        test_classes();
        test_primary_only();
        test_offset_climb();
        test_backpressure();
        test_random();

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Guard against a hang: well beyond the slowest correct run
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
sv/cct_pkg.sv
sv/cct_if.sv
sv/cct_ram.sv
sv/cct_front.sv
sv/cct_fifo.sv
sv/cct_back.sv
sv/char_class_tokenizer_core.sv
sim/testbench.sv
